// File: hdl/calendar_date_adder_unit_macros.svh
// Assertion helpers for the date adder checker.
`ifndef CALENDAR_DATE_ADDER_UNIT_MACROS_SVH
`define CALENDAR_DATE_ADDER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define CDAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define CDAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cdau_pkg.sv
package cdau_pkg;

  localparam int COUNT_BITS = 16;
  localparam logic [15:0] CNT_MASK =
    (COUNT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COUNT_BITS) - 32'd1);

  localparam int ACC_W = 23;
  localparam logic [15:0] YEAR_MAX = 16'hFFFF;
  localparam logic [8:0] LEAP_LAST = 9'd399;

  // year mod 400 from (year / 16) mod 25; 1311 / 2^15 is exact for 12-bit inputs
  localparam logic [10:0] YMOD_RECIP = 11'd1311;
  localparam logic [11:0] YMOD_DIV   = 12'd25;

  localparam logic [2:0] MODE_DAY     = 3'd0;
  localparam logic [2:0] MODE_WEEK    = 3'd1;
  localparam logic [2:0] MODE_MONTH   = 3'd2;
  localparam logic [2:0] MODE_YEAR    = 3'd3;
  localparam logic [2:0] MODE_DECADE  = 3'd4;
  localparam logic [2:0] MODE_CENTURY = 3'd5;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DISP,
    ST_DAY,
    ST_MON,
    ST_FIN
  } state_t;

  // leap test from year mod 400
  function automatic logic is_leap(input logic [8:0] r);
    is_leap = (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m) inside
      MONTH_FEB:                 month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  // scale applied to count at transfer time
  function automatic logic [6:0] mode_scale(input logic [2:0] mode);
    case (mode)
      MODE_WEEK:    mode_scale = 7'd7;
      MODE_DECADE:  mode_scale = 7'd10;
      MODE_CENTURY: mode_scale = 7'd100;
      default:      mode_scale = 7'd1;
    endcase
  endfunction

endpackage

// File: hdl/calendar_date_adder_unit.sv
// Sequence: year mod 400 in ST_DIV, then ST_DISP, then one month crossed per step
// (day/week) or stepped (month) before ST_FIN; year modes reduce year mod 400 twice.
// Throughput: one transfer at a time; busy drops in the result strobe cycle.
// Worst case is month mode with the full count.
// Reset: synchronous active-low rst_n returns to idle with no result pending.
// The result strobe lasts one cycle; the receiver cannot stall.
module calendar_date_adder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_count,
  input  logic [4:0]  in_start_day,
  input  logic [3:0]  in_start_month,
  input  logic [15:0] in_start_year,
  output logic        out_valid,
  output logic [4:0]  out_end_day,
  output logic [3:0]  out_end_month,
  output logic [15:0] out_end_year,
  output logic        out_year_overflow
);

  cdau_pkg::state_t state_r, state_nxt;

  logic [2:0]              mode_r, mode_nxt;
  logic [4:0]              day_r, day_nxt;
  logic [3:0]              mon_r, mon_nxt;
  logic [15:0]             year_r, year_nxt;
  logic [8:0]              ymod_r, ymod_nxt;
  logic [cdau_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    fix_r, fix_nxt;

  logic [15:0] dsh_r, dsh_nxt;
  logic [7:0]  dquo_r, dquo_nxt;
  logic        dph_r, dph_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  oday_r, oday_nxt;
  logic [3:0]  omon_r, omon_nxt;
  logic [15:0] oyear_r, oyear_nxt;
  logic        oovf_r, oovf_nxt;

  logic [15:0] cnt_m;
  logic [7:0]  dquo_c;
  logic [4:0]  drem25;
  logic        leap_cur, leap_new;
  logic [4:0]  dim_cur, dim_new, gap;
  logic [3:0]  mon_adv;
  logic [15:0] year_adv;
  logic [8:0]  ymod_adv;
  logic        wrap, sat;
  logic [23:0] ny;

  assign busy              = (state_r != cdau_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_end_day       = oday_r;
  assign out_end_month     = omon_r;
  assign out_end_year      = oyear_r;
  assign out_year_overflow = oovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdau_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r  <= mode_nxt;
    day_r   <= day_nxt;
    mon_r   <= mon_nxt;
    year_r  <= year_nxt;
    ymod_r  <= ymod_nxt;
    acc_r   <= acc_nxt;
    ovf_r   <= ovf_nxt;
    fix_r   <= fix_nxt;
    dsh_r   <= dsh_nxt;
    dquo_r  <= dquo_nxt;
    dph_r   <= dph_nxt;
    oday_r  <= oday_nxt;
    omon_r  <= omon_nxt;
    oyear_r <= oyear_nxt;
    oovf_r  <= oovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    year_nxt      = year_r;
    ymod_nxt      = ymod_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    fix_nxt       = fix_r;
    dsh_nxt       = dsh_r;
    dquo_nxt      = dquo_r;
    dph_nxt       = dph_r;
    out_valid_nxt = 1'b0;
    oday_nxt      = oday_r;
    omon_nxt      = omon_r;
    oyear_nxt     = oyear_r;
    oovf_nxt      = oovf_r;

    cnt_m    = in_count & cdau_pkg::CNT_MASK;
    dquo_c   = 8'((23'(dsh_r[15:4]) * 23'(cdau_pkg::YMOD_RECIP)) >> 15);
    drem25   = 5'(dsh_r[15:4] - 12'(dquo_r) * cdau_pkg::YMOD_DIV);
    leap_cur = cdau_pkg::is_leap(ymod_r);
    dim_cur  = cdau_pkg::month_len(mon_r, leap_cur);
    gap      = dim_cur - day_r;
    ny       = 24'(year_r) + 24'(acc_r);

    // month advance with year carry
    wrap     = (mon_r == cdau_pkg::MONTH_DEC);
    sat      = wrap && (year_r == cdau_pkg::YEAR_MAX);
    mon_adv  = wrap ? cdau_pkg::MONTH_JAN : mon_r + 4'd1;
    year_adv = wrap ? year_r + 16'd1 : year_r;
    ymod_adv = !wrap ? ymod_r : (ymod_r == cdau_pkg::LEAP_LAST) ? 9'd0 : ymod_r + 9'd1;
    leap_new = cdau_pkg::is_leap(ymod_adv);
    dim_new  = cdau_pkg::month_len(mon_adv, leap_new);

    case (state_r)
      cdau_pkg::ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          day_nxt  = (in_start_day == 5'd0) ? 5'd1 : in_start_day;
          if (in_start_month == 4'd0)                 mon_nxt = cdau_pkg::MONTH_JAN;
          else if (in_start_month > cdau_pkg::MONTH_DEC) mon_nxt = cdau_pkg::MONTH_DEC;
          else                                        mon_nxt = in_start_month;
          year_nxt  = in_start_year;
          acc_nxt   = cdau_pkg::ACC_W'(cnt_m) *
                      cdau_pkg::ACC_W'(cdau_pkg::mode_scale(in_mode));
          ovf_nxt   = 1'b0;
          fix_nxt   = 1'b0;
          dsh_nxt   = in_start_year;
          dph_nxt   = 1'b0;
          state_nxt = cdau_pkg::ST_DIV;
        end
      end

      // year mod 400 = 16 * ((year / 16) mod 25) + year mod 16, quotient first, then remainder
      cdau_pkg::ST_DIV: begin
        if (!dph_r) begin
          dquo_nxt = dquo_c;
          dph_nxt  = 1'b1;
        end else begin
          ymod_nxt  = {drem25, dsh_r[3:0]};
          state_nxt = cdau_pkg::ST_DISP;
        end
      end

      cdau_pkg::ST_DISP: begin
        if (fix_r) begin
          if (mon_r == cdau_pkg::MONTH_FEB && day_r == 5'd29 && !leap_cur)
            day_nxt = 5'd28;
          else if (mon_r == cdau_pkg::MONTH_FEB && day_r == 5'd28 && leap_cur)
            day_nxt = 5'd29;
          state_nxt = cdau_pkg::ST_FIN;
        end else begin
          if (day_r > dim_cur) day_nxt = dim_cur;
          case (mode_r)
            cdau_pkg::MODE_DAY, cdau_pkg::MODE_WEEK: state_nxt = cdau_pkg::ST_DAY;
            cdau_pkg::MODE_MONTH:                    state_nxt = cdau_pkg::ST_MON;
            cdau_pkg::MODE_YEAR, cdau_pkg::MODE_DECADE, cdau_pkg::MODE_CENTURY: begin
              if (ny > 24'(cdau_pkg::YEAR_MAX)) begin
                ovf_nxt   = 1'b1;
                state_nxt = cdau_pkg::ST_FIN;
              end else begin
                year_nxt  = ny[15:0];
                fix_nxt   = 1'b1;
                dsh_nxt   = ny[15:0];
                dph_nxt   = 1'b0;
                state_nxt = cdau_pkg::ST_DIV;
              end
            end
            default: state_nxt = cdau_pkg::ST_FIN;
          endcase
        end
      end

      // one month crossed per cycle
      cdau_pkg::ST_DAY: begin
        if (acc_r == '0) begin
          state_nxt = cdau_pkg::ST_FIN;
        end else if (acc_r <= cdau_pkg::ACC_W'(gap)) begin
          day_nxt   = day_r + acc_r[4:0];
          acc_nxt   = '0;
          state_nxt = cdau_pkg::ST_FIN;
        end else begin
          acc_nxt = acc_r - cdau_pkg::ACC_W'(gap + 5'd1);
          day_nxt = 5'd1;
          if (sat) begin
            ovf_nxt   = 1'b1;
            state_nxt = cdau_pkg::ST_FIN;
          end else begin
            mon_nxt  = mon_adv;
            year_nxt = year_adv;
            ymod_nxt = ymod_adv;
          end
        end
      end

      // one month per cycle, day clamped each step
      cdau_pkg::ST_MON: begin
        if (acc_r == '0) begin
          state_nxt = cdau_pkg::ST_FIN;
        end else if (sat) begin
          ovf_nxt   = 1'b1;
          state_nxt = cdau_pkg::ST_FIN;
        end else begin
          acc_nxt  = acc_r - cdau_pkg::ACC_W'(1);
          mon_nxt  = mon_adv;
          year_nxt = year_adv;
          ymod_nxt = ymod_adv;
          if (day_r > dim_new) day_nxt = dim_new;
        end
      end

      cdau_pkg::ST_FIN: begin
        out_valid_nxt = 1'b1;
        oovf_nxt      = ovf_r;
        oday_nxt      = ovf_r ? 5'd31 : day_r;
        omon_nxt      = ovf_r ? cdau_pkg::MONTH_DEC : mon_r;
        oyear_nxt     = ovf_r ? cdau_pkg::YEAR_MAX : year_r;
        state_nxt     = cdau_pkg::ST_IDLE;
      end

      default: state_nxt = cdau_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hdl/cdau_checker.sv
`include "calendar_date_adder_unit_macros.svh"

module cdau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [4:0]  out_end_day,
  input logic [3:0]  out_end_month,
  input logic [15:0] out_end_year,
  input logic        out_year_overflow
);

  logic date_ok;
  logic sat_ok;

  assign date_ok = (out_end_day != 5'd0) && (out_end_month != 4'd0) &&
                   (out_end_month <= cdau_pkg::MONTH_DEC);
  assign sat_ok  = (out_end_day == 5'd31) && (out_end_month == cdau_pkg::MONTH_DEC) &&
                   (out_end_year == cdau_pkg::YEAR_MAX);

  `CDAU_ASSERT_NXT(a_busy_after_transfer, start && !busy, busy, "busy low after transfer")

  `CDAU_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")

  `CDAU_ASSERT_IMP(a_date_range, out_valid, date_ok, "result date out of range")

  `CDAU_ASSERT_IMP(a_overflow_sat, out_valid && out_year_overflow, sat_ok, "overflow not saturated")

  `CDAU_ASSERT_IMP(a_strobe_after_busy, out_valid, $past(busy), "result without preceding work")

endmodule

bind calendar_date_adder_unit cdau_checker u_cdau_checker (.*);
